### design/qlm_pkg.sv
package qlm_pkg;

  localparam int THREADS  = 256;
  localparam int TID_W    = $clog2(THREADS);
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  typedef logic [TID_W-1:0] tid_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TRY     = 2'd0,
    CMD_ACQUIRE = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_UNUSED  = 2'd3
  } lock_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_BUSY    = 3'd2,
    ST_FREED   = 3'd3,
    ST_HANDED  = 3'd4,
    ST_ERROR   = 3'd5
  } lock_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_flags_t;

endpackage

### design/qlm_req_if.sv
interface qlm_req_if
  import qlm_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [TID_W-1:0]     thread_id;

  modport source (output valid, output cmd, output thread_id, input ready);
  modport sink   (input valid, input cmd, input thread_id, output ready);
endinterface

### design/qlm_rsp_if.sv
interface qlm_rsp_if
  import qlm_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [TID_W-1:0]     handed_to;

  modport source (output valid, output status, output handed_to, input ready);
  modport sink   (input valid, input status, input handed_to, output ready);
endinterface

### design/qlm_ram.sv
module qlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/qlm_ctrl.sv
module qlm_ctrl
  import qlm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  input  dp_flags_t flags,
  output logic      in_ready,
  output ctrl_cmd_t ctrl
);

  ctrl_state_t state_r, state_nxt;
  logic        can_commit;

  assign can_commit = !flags.out_full || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      S_EXEC: begin
        ctrl.commit = can_commit;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### design/qlm_dp.sv
module qlm_dp
  import qlm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           ctrl,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [TID_W-1:0]    in_thread_id,
  input  logic                out_ready,
  output dp_flags_t           flags,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [TID_W-1:0]    out_handed_to
);

  logic               busy_r, busy_nxt;
  tid_t               owner_r, owner_nxt;
  tid_t               tail_r, tail_nxt;
  logic [THREADS-1:0] succ_vld_r, succ_vld_nxt;
  logic [THREADS-1:0] waiting_r, waiting_nxt;
  lock_cmd_t          cmd_r;
  tid_t               tid_r;
  logic               out_valid_r, out_valid_nxt;
  lock_status_t       status_r, status_nxt;
  tid_t               handed_r, handed_nxt;
  logic               succ_we;
  tid_t               succ_rdata;

  qlm_ram #(
    .WIDTH (TID_W),
    .DEPTH (THREADS)
  ) u_succ_ram (
    .clk   (clk),
    .we    (succ_we),
    .waddr (tail_r),
    .wdata (tid_r),
    .re    (ctrl.load),
    .raddr (in_thread_id),
    .rdata (succ_rdata)
  );

  always_comb begin
    busy_nxt     = busy_r;
    owner_nxt    = owner_r;
    tail_nxt     = tail_r;
    succ_vld_nxt = succ_vld_r;
    waiting_nxt  = waiting_r;
    status_nxt   = ST_ERROR;
    handed_nxt   = '0;
    succ_we      = 1'b0;
    unique case (cmd_r) inside
      CMD_TRY, CMD_ACQUIRE: begin
        if (!busy_r) begin
          busy_nxt            = 1'b1;
          owner_nxt           = tid_r;
          tail_nxt            = tid_r;
          succ_vld_nxt[tid_r] = 1'b0;
          waiting_nxt[tid_r]  = 1'b0;
          status_nxt          = ST_GRANTED;
        end else if (cmd_r == CMD_TRY) begin
          status_nxt = ST_BUSY;
        end else if (owner_r != tid_r && !waiting_r[tid_r]) begin
          succ_we              = 1'b1;
          succ_vld_nxt[tail_r] = 1'b1;
          succ_vld_nxt[tid_r]  = 1'b0;
          waiting_nxt[tid_r]   = 1'b1;
          tail_nxt             = tid_r;
          status_nxt           = ST_QUEUED;
        end
      end
      CMD_RELEASE: begin
        if (busy_r && owner_r == tid_r) begin
          if (tail_r == tid_r) begin
            busy_nxt            = 1'b0;
            owner_nxt           = '0;
            tail_nxt            = '0;
            succ_vld_nxt[tid_r] = 1'b0;
            status_nxt          = ST_FREED;
          end else if (succ_vld_r[tid_r]) begin
            succ_vld_nxt[tid_r]     = 1'b0;
            waiting_nxt[succ_rdata] = 1'b0;
            owner_nxt               = succ_rdata;
            handed_nxt              = succ_rdata;
            status_nxt              = ST_HANDED;
          end
        end
      end
      default: begin
        status_nxt = ST_ERROR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      owner_r     <= '0;
      tail_r      <= '0;
      succ_vld_r  <= '0;
      waiting_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ctrl.commit) begin
        busy_r     <= busy_nxt;
        owner_r    <= owner_nxt;
        tail_r     <= tail_nxt;
        succ_vld_r <= succ_vld_nxt;
        waiting_r  <= waiting_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= lock_cmd_t'(in_cmd);
      tid_r <= in_thread_id;
    end
    if (ctrl.commit) begin
      status_r <= status_nxt;
      handed_r <= handed_nxt;
    end
  end

  assign flags.out_full = out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_handed_to  = handed_r;

endmodule

### design/queued_lock_manager.sv
// Queued lock manager: first-come queue lock for up to 256 threads.
// in_ch carries one request (cmd, thread_id); out_ch returns exactly one
// result (status, handed_to) per request, in request order.
// Commands: try takes a free lock or reports busy; acquire takes a free
// lock or links the thread behind the queue tail; release frees the lock
// or hands it to the next waiter, whose id comes back in handed_to; any
// other case, such as a release by a non-owner, returns error status.
// A transfer loads cmd and thread_id and starts the successor table read
// (registered read); the EXEC step then decides, updates lock state and
// loads the output register, raising out_ch.valid. A new request is
// taken only after that step, back in the idle state.
// The output register lets the next request transfer while a result
// still waits; if the receiver stalls, the following request holds in
// the decide step until the output register drains, so no result is lost.
// Reset (rst_n low, synchronous) frees the lock and clears the owner, the
// tail, every successor-valid and waiting bit and the output valid; the
// successor table itself needs no clearing and is ready at once.
module queued_lock_manager
  import qlm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  qlm_req_if.sink   in_ch,
  qlm_rsp_if.source out_ch
);

  ctrl_cmd_t ctrl;
  dp_flags_t flags;

  qlm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .flags     (flags),
    .in_ready  (in_ch.ready),
    .ctrl      (ctrl)
  );

  qlm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_cmd        (in_ch.cmd),
    .in_thread_id  (in_ch.thread_id),
    .out_ready     (out_ch.ready),
    .flags         (flags),
    .out_valid     (out_ch.valid),
    .out_status    (out_ch.status),
    .out_handed_to (out_ch.handed_to)
  );

endmodule
